// ===== hdl/bsa_pkg.sv =====
package bsa_pkg;

    localparam int WORD_W   = 32;
    localparam int WORD_LSB = 5;

    typedef logic [1:0] t_kind;

    localparam t_kind K_ALLOC   = 2'd0;
    localparam t_kind K_RELEASE = 2'd1;
    localparam t_kind K_REL_BAD = 2'd2;

    typedef struct packed {
        logic [9:0]  granted_index;
        logic        none_free;
        logic        release_error;
        logic [10:0] outstanding;
        logic [10:0] free_count;
    } t_result;

    typedef struct packed {
        logic                found;
        logic [WORD_LSB-1:0] pos;
    } t_find;

    function automatic t_find find_zero(input logic [WORD_W-1:0] bits);
        t_find res;
        res.found = 1'b0;
        res.pos   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!bits[i]) begin
                res.found = 1'b1;
                res.pos   = WORD_LSB'(i);
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/bsa_ram.sv =====
module bsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bsa_queue.sv =====
module bsa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wr;
    logic             r_rd;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr] <= i_data;
        end
    end

    assign o_data  = r_data[r_rd];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

endmodule

// ===== hdl/bsa_front.sv =====
module bsa_front #(
    parameter int MAX_SECTIONS = 1024,
    parameter int CNT_W        = 11,
    parameter int IDX_W        = 10
) (
    input  logic              i_start,
    input  logic              i_operation,
    input  logic [9:0]        i_release_index,
    input  logic [10:0]       i_section_count,
    input  logic              i_full,
    output logic              o_busy,
    output logic              o_push,
    output bsa_pkg::t_kind    o_kind,
    output logic [IDX_W-1:0]  o_idx,
    output logic [CNT_W-1:0]  o_count
);

    localparam int W1    = (CNT_W > 11) ? CNT_W : 11;
    localparam int CMP_W = (W1 > IDX_W) ? W1 : IDX_W;

    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] max_ext;
    logic [CMP_W-1:0] active;
    logic [CMP_W-1:0] idx_ext;

    always_comb begin
        count_ext = CMP_W'(i_section_count);
        max_ext   = CMP_W'(MAX_SECTIONS);
        active    = (count_ext > max_ext) ? max_ext : count_ext;
        idx_ext   = CMP_W'(i_release_index);
        if (!i_operation) begin
            o_kind = bsa_pkg::K_ALLOC;
        end else if (idx_ext < active) begin
            o_kind = bsa_pkg::K_RELEASE;
        end else begin
            o_kind = bsa_pkg::K_REL_BAD;
        end
    end

    assign o_idx   = idx_ext[IDX_W-1:0];
    assign o_count = active[CNT_W-1:0];
    assign o_push  = i_start && !i_full;
    assign o_busy  = i_full;

endmodule

// ===== hdl/bsa_back.sv =====
module bsa_back #(
    parameter int ROWS  = 32,
    parameter int ROW_W = 5,
    parameter int IDX_W = 10,
    parameter int CNT_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  bsa_pkg::t_kind              i_cmd_kind,
    input  logic [IDX_W-1:0]            i_cmd_idx,
    input  logic [CNT_W-1:0]            i_cmd_count,
    output logic                        o_ram_we,
    output logic [ROW_W-1:0]            o_ram_waddr,
    output logic [bsa_pkg::WORD_W-1:0]  o_ram_wdata,
    output logic [ROW_W-1:0]            o_ram_raddr,
    input  logic [bsa_pkg::WORD_W-1:0]  i_ram_rdata,
    output logic                        o_done,
    output bsa_pkg::t_result            o_res
);

    localparam int WW      = bsa_pkg::WORD_W;
    localparam int WL      = bsa_pkg::WORD_LSB;
    localparam int CHUNKS  = (ROWS + WW - 1) / WW;
    localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam int OW      = (CNT_W > 11) ? CNT_W : 11;
    localparam int GW      = (IDX_W > 10) ? IDX_W : 10;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0]          r_state, n_state;
    bsa_pkg::t_kind      r_kind, n_kind;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CHUNK_W-1:0]  r_chunk, n_chunk;
    logic [ROW_W-1:0]    r_row, n_row;
    logic [WL-1:0]       r_bit, n_bit;
    logic                r_found, n_found;
    logic [WW-1:0]       r_word, n_word;
    logic [CNT_W-1:0]    r_total, n_total;
    logic [ROWS-1:0]     r_valid, n_valid;
    logic [ROWS-1:0]     r_full, n_full;
    logic                r_done, n_done;
    bsa_pkg::t_result    r_res, n_res;

    logic [CHUNKS*WW-1:0]      full_pad;
    logic [WW-1:0]             chunk_bits;
    bsa_pkg::t_find            scan_find;
    bsa_pkg::t_find            word_find;
    logic [CHUNK_W+WL-1:0]     scan_pos;
    logic [WW-1:0]             cur_word;
    logic [WW-1:0]             rel_mask;
    logic [WW-1:0]             set_word;
    logic [IDX_W-1:0]          grant_idx;
    logic                      grant_ok;
    logic                      emit;
    logic                      e_none;
    logic                      e_err;
    logic                      e_grant;
    logic [CNT_W-1:0]          res_count;
    logic [CNT_W-1:0]          free_w;
    logic [OW-1:0]             out_ext;
    logic [OW-1:0]             free_ext;
    logic [GW-1:0]             grant_ext;

    always_comb begin
        for (int i = 0; i < CHUNKS * WW; i++) begin
            full_pad[i] = (i < ROWS) ? r_full[i] : 1'b1;
        end
    end

    always_comb begin
        chunk_bits = full_pad[r_chunk*WW +: WW];
        scan_find  = bsa_pkg::find_zero(chunk_bits);
        scan_pos   = {r_chunk, scan_find.pos};
        cur_word   = r_valid[r_row] ? i_ram_rdata : '0;
        word_find  = bsa_pkg::find_zero(cur_word);
        rel_mask   = WW'(1) << r_idx[WL-1:0];
        set_word   = r_word | (WW'(1) << r_bit);
        grant_idx  = {r_row, r_bit};
        grant_ok   = r_found && (CMP_W'(grant_idx) < CMP_W'(r_count));
    end

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_idx       = r_idx;
        n_count     = r_count;
        n_chunk     = r_chunk;
        n_row       = r_row;
        n_bit       = r_bit;
        n_found     = r_found;
        n_word      = r_word;
        n_total     = r_total;
        n_valid     = r_valid;
        n_full      = r_full;
        o_pop       = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_row;
        o_ram_wdata = set_word;
        o_ram_raddr = r_row;
        emit        = 1'b0;
        e_none      = 1'b0;
        e_err       = 1'b0;
        e_grant     = 1'b0;
        res_count   = r_count;

        unique case (r_state)
            S_IDLE: begin
                o_ram_raddr = i_cmd_idx[IDX_W-1:WL];
                res_count   = i_cmd_count;
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_kind  = i_cmd_kind;
                    n_idx   = i_cmd_idx;
                    n_count = i_cmd_count;
                    n_row   = i_cmd_idx[IDX_W-1:WL];
                    n_chunk = '0;
                    unique case (i_cmd_kind)
                        bsa_pkg::K_ALLOC:   n_state = S_SCAN;
                        bsa_pkg::K_RELEASE: n_state = S_READ;
                        default: begin
                            emit  = 1'b1;
                            e_err = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                o_ram_raddr = scan_pos[ROW_W-1:0];
                if (scan_find.found) begin
                    n_row   = scan_pos[ROW_W-1:0];
                    n_state = S_READ;
                end else if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                    emit    = 1'b1;
                    e_none  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_chunk = r_chunk + CHUNK_W'(1);
                end
            end
            S_READ: begin
                if (r_kind == bsa_pkg::K_ALLOC) begin
                    n_word  = cur_word;
                    n_bit   = word_find.pos;
                    n_found = word_find.found;
                    n_state = S_COMMIT;
                end else begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if ((cur_word & rel_mask) != '0) begin
                        o_ram_we     = 1'b1;
                        o_ram_wdata  = cur_word & ~rel_mask;
                        n_valid[r_row] = 1'b1;
                        n_full[r_row]  = 1'b0;
                        n_total      = r_total - CNT_W'(1);
                    end else begin
                        e_err = 1'b1;
                    end
                end
            end
            S_COMMIT: begin
                emit    = 1'b1;
                n_state = S_IDLE;
                if (grant_ok) begin
                    o_ram_we       = 1'b1;
                    n_valid[r_row] = 1'b1;
                    n_full[r_row]  = &set_word;
                    n_total        = r_total + CNT_W'(1);
                    e_grant        = 1'b1;
                end else begin
                    e_none = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        free_w    = (res_count > n_total) ? (res_count - n_total) : '0;
        out_ext   = OW'(n_total);
        free_ext  = OW'(free_w);
        grant_ext = e_grant ? GW'(grant_idx) : '0;
        n_done    = emit;
        n_res     = r_res;
        if (emit) begin
            n_res.granted_index = grant_ext[9:0];
            n_res.none_free     = e_none;
            n_res.release_error = e_err;
            n_res.outstanding   = out_ext[10:0];
            n_res.free_count    = free_ext[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_valid <= '0;
            r_full  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_valid <= n_valid;
            r_full  <= n_full;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_idx   <= n_idx;
        r_count <= n_count;
        r_chunk <= n_chunk;
        r_row   <= n_row;
        r_bit   <= n_bit;
        r_found <= n_found;
        r_word  <= n_word;
        r_res   <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== hdl/bitmap_slot_allocator.sv =====
// First-fit section allocator over a one-bit-per-section map held in 32-bit rows
// of a RAM, with a full flag and a written flag per row in flip-flops, so the map
// reads as all free right after reset with no clearing pass. An allocate walks
// the row full flags (32 rows a cycle), then does the registered RAM read and
// the read-modify-write of the row. A release in range reads its RAM row and
// writes it back; a release out of range is rejected without touching the map.
// Up to two items wait in a queue in front of the allocator; busy rises while
// that queue is full. Each result appears for one cycle with o_done and cannot
// be held off.
module bitmap_slot_allocator #(
    parameter int MAX_SECTIONS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [9:0]  i_release_index,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output logic        o_done,
    output logic [9:0]  o_granted_index,
    output logic        o_none_free,
    output logic        o_release_error,
    output logic [10:0] o_outstanding,
    output logic [10:0] o_free_count
);

    localparam int WW    = bsa_pkg::WORD_W;
    localparam int ROWS  = (MAX_SECTIONS + WW - 1) / WW;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = ROW_W + bsa_pkg::WORD_LSB;
    localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
    localparam int Q_W   = $bits(bsa_pkg::t_kind) + IDX_W + CNT_W;

    logic [10:0]          r_section_count;
    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;
    bsa_pkg::t_kind       f_kind;
    logic [IDX_W-1:0]     f_idx;
    logic [CNT_W-1:0]     f_count;
    logic [Q_W-1:0]       q_head;
    bsa_pkg::t_kind       b_kind;
    logic [IDX_W-1:0]     b_idx;
    logic [CNT_W-1:0]     b_count;
    logic                 ram_we;
    logic [ROW_W-1:0]     ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [ROW_W-1:0]     ram_raddr;
    logic [WW-1:0]        ram_rdata;
    bsa_pkg::t_result     res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_section_count <= 11'd1024;
        end else if (i_cfg_we) begin
            r_section_count <= i_cfg_wdata;
        end
    end

    bsa_front #(
        .MAX_SECTIONS (MAX_SECTIONS),
        .CNT_W        (CNT_W),
        .IDX_W        (IDX_W)
    ) u_front (
        .i_start         (start),
        .i_operation     (i_operation),
        .i_release_index (i_release_index),
        .i_section_count (r_section_count),
        .i_full          (q_full),
        .o_busy          (busy),
        .o_push          (q_push),
        .o_kind          (f_kind),
        .o_idx           (f_idx),
        .o_count         (f_count)
    );

    bsa_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({f_kind, f_idx, f_count}),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_kind, b_idx, b_count} = q_head;

    bsa_back #(
        .ROWS  (ROWS),
        .ROW_W (ROW_W),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .i_cmd_kind  (b_kind),
        .i_cmd_idx   (b_idx),
        .i_cmd_count (b_count),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_done      (o_done),
        .o_res       (res)
    );

    bsa_ram #(
        .WIDTH (WW),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_granted_index = res.granted_index;
    assign o_none_free     = res.none_free;
    assign o_release_error = res.release_error;
    assign o_outstanding   = res.outstanding;
    assign o_free_count    = res.free_count;

endmodule

// ===== hdl/bsa_checker.sv =====
module bsa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [9:0]  o_granted_index,
    input logic        o_none_free,
    input logic        o_release_error,
    input logic [10:0] o_outstanding
);

    logic [2:0]  r_pending;
    logic [10:0] r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_last    <= '0;
        end else begin
            r_pending <= r_pending + 3'(start && !busy) - 3'(o_done);
            if (o_done) begin
                r_last <= o_outstanding;
            end
        end
    end

    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_none_free |-> !o_release_error && (o_granted_index == 10'd0))
        else $error("none_free result carries a grant or a release error");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_pending != 3'd0)
        else $error("result without an accepted item");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_none_free || o_release_error) |-> o_outstanding == r_last)
        else $error("failed item changed the outstanding count");

    a_ok_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_none_free && !o_release_error |->
            (o_outstanding == r_last + 11'd1) || (o_outstanding == r_last - 11'd1))
        else $error("successful item moved the outstanding count by other than one");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_done          (o_done),
    .o_granted_index (o_granted_index),
    .o_none_free     (o_none_free),
    .o_release_error (o_release_error),
    .o_outstanding   (o_outstanding)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    localparam logic OP_ALLOC      = 1'b0;
    localparam logic OP_RELEASE    = 1'b1;
    localparam int   SECTIONS_MAX  = 1024;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   TAIL_CYCLES   = 32;
    localparam int   STALL_LIMIT   = 2000;
    localparam int   QUIET_TAIL    = 120;

    typedef enum logic [1:0] {
        REQ_ITEM,
        REQ_CFG,
        REQ_DRAIN
    } t_req_kind;

    typedef struct {
        t_req_kind   kind;
        logic        op;
        logic [9:0]  index;
        logic [10:0] sections;
    } t_request;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        i_operation     = 1'b0;
    logic [9:0]  i_release_index = '0;
    logic        i_cfg_we        = 1'b0;
    logic [10:0] i_cfg_wdata     = '0;
    logic        busy;
    logic        o_done;
    logic [9:0]  o_granted_index;
    logic        o_none_free;
    logic        o_release_error;
    logic [10:0] o_outstanding;
    logic [10:0] o_free_count;

    t_request          requests_todo[$];
    bsa_pkg::t_result  outcomes_due[$];

    bit [SECTIONS_MAX-1:0] sect_used    = '0;
    int                    sect_held    = 0;
    logic [10:0]           sect_count   = 11'd1024;
    int                    gen_held     = 0;
    int                    idle_pct     = 10;
    int                    gap_left     = 0;
    int                    settle_left  = SETTLE_CYCLES;
    int                    stall_cycles = 0;
    int                    mismatches   = 0;
    int                    results_seen = 0;

    always #5 i_clk = ~i_clk;

    bitmap_slot_allocator #(
        .MAX_SECTIONS(SECTIONS_MAX)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_release_index(i_release_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_granted_index(o_granted_index),
        .o_none_free    (o_none_free),
        .o_release_error(o_release_error),
        .o_outstanding  (o_outstanding),
        .o_free_count   (o_free_count)
    );

    function automatic bsa_pkg::t_result section_outcome(input logic op,
                                                         input logic [9:0] index);
        bsa_pkg::t_result res;
        int      span;
        logic    found;
        res   = '0;
        span  = (sect_count > SECTIONS_MAX) ? SECTIONS_MAX : int'(sect_count);
        found = 1'b0;
        if (op == OP_ALLOC) begin
            for (int i = 0; i < span; i++) begin
                if (!found && !sect_used[i]) begin
                    sect_used[i]      = 1'b1;
                    sect_held++;
                    res.granted_index = 10'(i);
                    found             = 1'b1;
                end
            end
            res.none_free = !found;
        end else if (index < span && sect_used[index]) begin
            sect_used[index] = 1'b0;
            sect_held--;
        end else begin
            res.release_error = 1'b1;
        end
        res.outstanding = 11'(sect_held);
        res.free_count  = (span > sect_held) ? 11'(span - sect_held) : '0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result %0d: %s got %0d want %0d", $time, results_seen, what, got, want);
        mismatches++;
    endtask

    task automatic add_item(input logic op, input int index);
        t_request r;
        r.kind     = REQ_ITEM;
        r.op       = op;
        r.index    = 10'(index);
        r.sections = '0;
        requests_todo.push_back(r);
    endtask

    task automatic add_cfg(input int sections);
        t_request r;
        r.kind     = REQ_CFG;
        r.op       = OP_ALLOC;
        r.index    = '0;
        r.sections = 11'(sections);
        requests_todo.push_back(r);
    endtask

    task automatic add_drain();
        t_request r;
        r.kind     = REQ_DRAIN;
        r.op       = OP_ALLOC;
        r.index    = '0;
        r.sections = '0;
        requests_todo.push_back(r);
    endtask

    task automatic add_random_phase(input int sections, input int n, input int alloc_pct);
        int span;
        int hi;
        add_cfg(sections);
        span = (sections > SECTIONS_MAX) ? SECTIONS_MAX : sections;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 199) == 0) begin
                add_drain();
            end
            if ($urandom_range(1, 100) <= alloc_pct) begin
                add_item(OP_ALLOC, $urandom_range(0, 1023));
                if (gen_held < span) begin
                    gen_held++;
                end
            end else begin
                hi = gen_held + 4;
                if (hi > span - 1) begin
                    hi = span - 1;
                end
                if (hi < 0 || $urandom_range(0, 9) == 0) begin
                    add_item(OP_RELEASE, $urandom_range(0, 1023));
                end else begin
                    add_item(OP_RELEASE, $urandom_range(0, hi));
                    if (gen_held > 0) begin
                        gen_held--;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin : driver
        logic        took;
        logic        nxt_start;
        logic        nxt_we;
        logic        nxt_op;
        logic [9:0]  nxt_index;
        logic [10:0] nxt_wdata;
        t_request    head;
        nxt_start = 1'b0;
        nxt_we    = 1'b0;
        nxt_op    = i_operation;
        nxt_index = i_release_index;
        nxt_wdata = i_cfg_wdata;
        took      = i_rst_n && start && !busy;
        if (took) begin
            outcomes_due.push_back(section_outcome(i_operation, i_release_index));
        end
        if (!i_rst_n) begin
            gap_left    = 0;
            settle_left = SETTLE_CYCLES;
        end else if (start && busy) begin
            nxt_start = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (requests_todo.size() > 0) begin
            head = requests_todo[0];
            if (head.kind == REQ_ITEM) begin
                if (requests_todo.size() > QUIET_TAIL && $urandom_range(1, 100) <= idle_pct) begin
                    gap_left = $urandom_range(0, 15);
                end else begin
                    requests_todo.delete(0);
                    nxt_start = 1'b1;
                    nxt_op    = head.op;
                    nxt_index = head.index;
                end
            end else if (took || outcomes_due.size() != 0) begin
                settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
                settle_left--;
            end else begin
                requests_todo.delete(0);
                idle_pct    = $urandom_range(0, 30);
                settle_left = SETTLE_CYCLES;
                if (head.kind == REQ_CFG) begin
                    nxt_we     = 1'b1;
                    nxt_wdata  = head.sections;
                    sect_count = head.sections;
                end
            end
        end
        start           <= nxt_start;
        i_operation     <= nxt_op;
        i_release_index <= nxt_index;
        i_cfg_we        <= nxt_we;
        i_cfg_wdata     <= nxt_wdata;
    end

    always @(posedge i_clk) begin : monitor
        bsa_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("result with nothing due, granted_index", o_granted_index, 0);
            end else begin
                want = outcomes_due.pop_front();
                if (o_granted_index !== want.granted_index) begin
                    report_mismatch("granted_index", o_granted_index, want.granted_index);
                end
                if (o_none_free !== want.none_free) begin
                    report_mismatch("none_free", o_none_free, want.none_free);
                end
                if (o_release_error !== want.release_error) begin
                    report_mismatch("release_error", o_release_error, want.release_error);
                end
                if (o_outstanding !== want.outstanding) begin
                    report_mismatch("outstanding", o_outstanding, want.outstanding);
                end
                if (o_free_count !== want.free_count) begin
                    report_mismatch("free_count", o_free_count, want.free_count);
                end
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        add_item(OP_ALLOC, 1023);
        add_item(OP_RELEASE, 1023);
        add_item(OP_RELEASE, 0);
        add_item(OP_RELEASE, 0);
        add_cfg(4);
        repeat (5) add_item(OP_ALLOC, 0);
        add_item(OP_RELEASE, 3);
        add_item(OP_RELEASE, 3);
        add_item(OP_RELEASE, 1023);
        add_item(OP_ALLOC, 512);
        // shrink while sections are held
        add_cfg(2);
        add_item(OP_ALLOC, 0);
        add_item(OP_RELEASE, 3);
        add_item(OP_RELEASE, 1);
        add_item(OP_ALLOC, 0);
        add_cfg(4);
        add_item(OP_RELEASE, 3);
        add_cfg(0);
        add_item(OP_ALLOC, 0);
        add_item(OP_RELEASE, 0);
        add_cfg(2047);
        add_item(OP_ALLOC, 0);
        add_item(OP_RELEASE, 1023);
        add_item(OP_RELEASE, 0);

        gen_held = 4;
        add_random_phase(1024, 800, 93);
        add_drain();
        add_random_phase(700, 150, 45);
        add_random_phase(2047, 60, 60);
        repeat (4) add_random_phase($urandom_range(1, 24), 60, 60);
        add_random_phase(1, 40, 50);
        add_random_phase(1024, 140, 50);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(negedge i_clk);
        end while (requests_todo.size() != 0 || start || outcomes_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (outcomes_due.size() != 0) begin
            report_mismatch("results still due", outcomes_due.size(), 0);
        end
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/bsa_pkg.sv
hdl/bsa_ram.sv
hdl/bsa_queue.sv
hdl/bsa_front.sv
hdl/bsa_back.sv
hdl/bitmap_slot_allocator.sv
hdl/bsa_checker.sv
dv/tb.sv
